@@ rtl/trapezoidal_trajectory_generator_defines.svh @@
// assertion macros used by the trajectory generator controller
`ifndef TRAPEZOIDAL_TRAJECTORY_GENERATOR_DEFINES_SVH
`define TRAPEZOIDAL_TRAJECTORY_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TTG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttg same-cycle check failed");
`define TTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttg next-cycle check failed");
`else
`define TTG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/ttg_pkg.sv @@
// shared widths, codes and controller/datapath interface types
`default_nettype none

package ttg_pkg;

    localparam int POS_W      = 48;
    localparam int TICK_W     = 24;
    localparam int VEL_W      = 32;
    localparam int ACC_W      = 24;
    localparam int MAXV_W     = 31;
    localparam int MAXA_W     = 23;
    localparam int PHASE_W    = 2;
    localparam int MUL_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MAXV_W;

    localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(6710886);
    localparam logic [MAXA_W-1:0] MAXA_RESET = MAXA_W'(8389);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL    = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL,
        PH_IDLE
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_VT,
        OP_AT,
        OP_ATT_LO,
        OP_ATT_HI,
        OP_VV,
        OP_REM_LO,
        OP_REM_HI,
        OP_EVAL
    } op_t;

    typedef struct packed {
        op_t  op;
        logic capture;
        logic commit;
    } ttg_cmd_t;

    typedef struct packed {
        logic phase_idle;
    } ttg_status_t;

endpackage

`default_nettype wire

@@ rtl/ttg_ctrl.sv @@
// sequencer for the tick transaction: capture, multiply steps, commit
`default_nettype none
`include "trapezoidal_trajectory_generator_defines.svh"

module ttg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ttg_pkg::ttg_status_t sts,
    output ttg_pkg::ttg_cmd_t    cmd
);
    import ttg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_COMMIT
    } state_t;

    localparam int              STEP_W    = 3;
    localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '{op: OP_NONE, capture: 1'b0, commit: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    // an idle tick needs no arithmetic
                    state_next  = sts.phase_idle ? S_COMMIT : S_RUN;
                end
            end
            S_RUN:
            begin
                case (step_reg)
                    3'd0:    cmd.op = OP_VT;
                    3'd1:    cmd.op = OP_AT;
                    3'd2:    cmd.op = OP_ATT_LO;
                    3'd3:    cmd.op = OP_ATT_HI;
                    3'd4:    cmd.op = OP_VV;
                    3'd5:    cmd.op = OP_REM_LO;
                    3'd6:    cmd.op = OP_REM_HI;
                    default: cmd.op = OP_EVAL;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TTG_ASSERT_NEXT(a_run_starts, clk, rst_n, in_valid && in_ready && !sts.phase_idle, cmd.op == OP_VT)
    `TTG_ASSERT_SAME(a_commit_slot_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `TTG_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_reg && in_ready)

endmodule

`default_nettype wire

@@ rtl/ttg_datapath.sv @@
// profile state, shared multiplier, segment arithmetic and phase decisions
`default_nettype none

module ttg_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [ttg_pkg::POS_W-1:0]      target_position,
    input  ttg_pkg::ttg_cmd_t                     cmd,
    output ttg_pkg::ttg_status_t                  sts,
    output logic signed [ttg_pkg::POS_W-1:0]      position,
    output logic signed [ttg_pkg::VEL_W-1:0]      velocity,
    output logic signed [ttg_pkg::ACC_W-1:0]      acceleration,
    output logic [ttg_pkg::PHASE_W-1:0]           phase
);
    import ttg_pkg::*;

    localparam int VT_W     = VEL_W + TICK_W;
    localparam int AT_W     = MAXA_W + TICK_W;
    localparam int ATT_LO_W = 2 * TICK_W;
    localparam int HALF_W   = AT_W + TICK_W - 1;
    localparam int M_W      = (HALF_W > POS_W + 1) ? HALF_W : POS_W + 1;
    localparam int VS_W     = AT_W + 2;
    localparam int REM_LO_W = POS_W / 2;
    localparam int REM_HI_W = POS_W - REM_LO_W;
    localparam int RA_W     = POS_W + MAXA_W;
    localparam int VV_W     = 2 * VEL_W;
    localparam int CMP_W    = (RA_W + 2 > VV_W) ? RA_W + 2 : VV_W;
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX_S = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN_S = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [TICK_W-1:0]       TICK_MAX  = {TICK_W{1'b1}};

    // base plus or minus m, clamped to the position range
    function automatic logic signed [POS_W-1:0] pos_add(
        input logic signed [POS_W-1:0] base,
        input logic                    neg,
        input logic [M_W-1:0]          m
    );
        logic signed [POS_W:0]   base_x;
        logic signed [POS_W:0]   room_s;
        logic signed [POS_W-1:0] result;
        base_x = (POS_W+1)'(base);
        if (neg)
        begin
            room_s = base_x - (POS_W+1)'(POS_MIN);
        end
        else
        begin
            room_s = (POS_W+1)'(POS_MAX) - base_x;
        end
        if (m >= M_W'(unsigned'(room_s)))
        begin
            result = neg ? POS_MIN : POS_MAX;
        end
        else if (neg)
        begin
            result = base - m[POS_W-1:0];
        end
        else
        begin
            result = base + m[POS_W-1:0];
        end
        return result;
    endfunction

    // profile state
    phase_t                   phase_reg, phase_next;
    logic                     moving_neg_reg, moving_neg_next;
    logic signed [POS_W-1:0]  p0_reg, p0_next;
    logic signed [VEL_W-1:0]  v0_reg, v0_next;
    logic [TICK_W-1:0]        t_reg, t_next;
    logic signed [POS_W-1:0]  accepted_reg, accepted_next;
    logic signed [POS_W-1:0]  held_pos_reg, held_pos_next;
    logic signed [VEL_W-1:0]  held_vel_reg, held_vel_next;
    logic signed [ACC_W-1:0]  held_acc_reg, held_acc_next;
    logic [MAXV_W-1:0]        max_vel_reg, max_vel_next;
    logic [MAXA_W-1:0]        max_acc_reg, max_acc_next;

    // per-tick working registers
    logic signed [POS_W-1:0]  tgt_reg;
    logic [VT_W-1:0]          vt_reg;
    logic [AT_W-1:0]          at_reg;
    logic [ATT_LO_W-1:0]      att_lo_reg;
    logic [AT_W-1:0]          att_hi_reg;
    logic [VV_W-1:0]          vv_reg;
    logic [HALF_W-1:0]        half_reg, half_next;
    logic signed [POS_W-1:0]  p_lin_reg, p_lin_next;
    logic [POS_W-1:0]         rem_reg, rem_next;
    logic signed [VEL_W-1:0]  vel_reg, vel_next;
    logic signed [POS_W-1:0]  p_acc_reg, p_acc_next;
    logic [REM_LO_W+MAXA_W-1:0] ra_lo_reg;
    logic [REM_HI_W+MAXA_W-1:0] ra_hi_reg;
    logic                     hit_d_reg, hit_d_next;
    logic                     hit_v_reg, hit_v_next;
    logic                     stop_reg, stop_next;
    logic                     zero_reg, zero_next;

    logic                     v0_neg;
    logic [VEL_W-1:0]         v0_mag;
    logic                     acc_neg;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        prod;
    logic signed [POS_W:0]    d_tp, d_tp_neg;
    logic signed [VS_W-1:0]   at_s, vsum;
    logic [HALF_W:0]          att_sum;
    logic signed [POS_W:0]    d_tp0, d_pp0;
    logic [POS_W:0]           r_abs, r_half, dpp_abs;
    logic [VEL_W-1:0]         vel_mag;
    logic [RA_W:0]            ra_sum;
    logic signed [ACC_W-1:0]  acc_mag_s;
    logic                     seg_reset;
    logic [TICK_W-1:0]        t_base;

    assign v0_neg  = v0_reg[VEL_W-1];
    assign v0_mag  = v0_neg ? VEL_W'(-v0_reg) : VEL_W'(v0_reg);
    // sign of the acceleration term for the current segment
    assign acc_neg = (phase_reg == PH_ACCEL) ? (p0_reg > tgt_reg) : !moving_neg_reg;

    // shared multiplier, one product per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_VT:
            begin
                mul_a = MUL_W'(v0_mag);
                mul_b = MUL_W'(t_reg);
            end
            OP_AT:
            begin
                mul_a = MUL_W'(max_acc_reg);
                mul_b = MUL_W'(t_reg);
            end
            OP_ATT_LO:
            begin
                mul_a = MUL_W'(at_reg[TICK_W-1:0]);
                mul_b = MUL_W'(t_reg);
            end
            OP_ATT_HI:
            begin
                mul_a = MUL_W'(at_reg[AT_W-1:TICK_W]);
                mul_b = MUL_W'(t_reg);
            end
            OP_VV:
            begin
                mul_a = MUL_W'(v0_mag);
                mul_b = MUL_W'(v0_mag);
            end
            OP_REM_LO:
            begin
                mul_a = MUL_W'(rem_reg[REM_LO_W-1:0]);
                mul_b = MUL_W'(max_acc_reg);
            end
            OP_REM_HI:
            begin
                mul_a = MUL_W'(rem_reg[POS_W-1:REM_LO_W]);
                mul_b = MUL_W'(max_acc_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // linear part of the position: p0 + v0*t
    assign p_lin_next = pos_add(p0_reg, v0_neg, M_W'(vt_reg));

    // distance left ahead of the cruise position, zero once passed
    assign d_tp     = (POS_W+1)'(tgt_reg) - (POS_W+1)'(p_lin_reg);
    assign d_tp_neg = -d_tp;
    always_comb
    begin
        if (!moving_neg_reg)
        begin
            rem_next = (d_tp > 0) ? d_tp[POS_W-1:0] : '0;
        end
        else
        begin
            rem_next = (d_tp < 0) ? d_tp_neg[POS_W-1:0] : '0;
        end
    end

    // v0 +/- a*t, clamped to 32 bits
    assign at_s = signed'(VS_W'(at_reg));
    assign vsum = VS_W'(v0_reg) + (acc_neg ? -at_s : at_s);
    always_comb
    begin
        if (vsum > VS_W'(VEL_MAX_S))
        begin
            vel_next = VEL_MAX_S;
        end
        else if (vsum < VS_W'(VEL_MIN_S))
        begin
            vel_next = VEL_MIN_S;
        end
        else
        begin
            vel_next = vsum[VEL_W-1:0];
        end
    end

    // floor(a*t*t/2) from the two partial products
    assign att_sum   = ((HALF_W+1)'(att_hi_reg) << TICK_W) + (HALF_W+1)'(att_lo_reg);
    assign half_next = att_sum[HALF_W:1];

    assign p_acc_next = pos_add(p_lin_reg, acc_neg, M_W'(half_reg));

    // phase exit tests
    assign d_tp0   = (POS_W+1)'(tgt_reg) - (POS_W+1)'(p0_reg);
    assign d_pp0   = (POS_W+1)'(p_acc_reg) - (POS_W+1)'(p0_reg);
    assign r_abs   = d_tp0[POS_W] ? unsigned'(-d_tp0) : unsigned'(d_tp0);
    assign dpp_abs = d_pp0[POS_W] ? unsigned'(-d_pp0) : unsigned'(d_pp0);
    assign r_half  = (r_abs >> 1) + (POS_W+1)'(r_abs[0]);
    assign hit_d_next = (dpp_abs >= r_half);

    assign vel_mag    = vel_reg[VEL_W-1] ? VEL_W'(-vel_reg) : VEL_W'(vel_reg);
    assign hit_v_next = (vel_mag >= VEL_W'(max_vel_reg));

    // stopping test cross-multiplied: 2*a*rem <= v0^2
    assign ra_sum    = ((RA_W+1)'(ra_hi_reg) << REM_LO_W) + (RA_W+1)'(ra_lo_reg);
    assign stop_next = (CMP_W'({ra_sum, 1'b0}) <= CMP_W'(vv_reg));

    assign zero_next = moving_neg_reg ? !vel_reg[VEL_W-1]
                                      : (vel_reg[VEL_W-1] || (vel_reg == '0));

    assign acc_mag_s = signed'(ACC_W'(max_acc_reg));

    // state update at commit
    always_comb
    begin
        phase_next      = phase_reg;
        moving_neg_next = moving_neg_reg;
        p0_next         = p0_reg;
        v0_next         = v0_reg;
        accepted_next   = accepted_reg;
        held_pos_next   = held_pos_reg;
        held_vel_next   = held_vel_reg;
        held_acc_next   = held_acc_reg;
        seg_reset       = 1'b0;
        t_base          = t_reg;
        t_next          = t_reg;

        if (cmd.commit)
        begin
            case (phase_reg)
                PH_ACCEL:
                begin
                    moving_neg_next = acc_neg;
                    held_pos_next   = p_acc_reg;
                    held_vel_next   = vel_reg;
                    held_acc_next   = acc_neg ? -acc_mag_s : acc_mag_s;
                    // half distance wins over the velocity limit
                    if (hit_d_reg || hit_v_reg)
                    begin
                        phase_next = hit_d_reg ? PH_DECEL : PH_CRUISE;
                        p0_next    = p_acc_reg;
                        v0_next    = vel_reg;
                        seg_reset  = 1'b1;
                    end
                end
                PH_CRUISE:
                begin
                    held_pos_next = p_lin_reg;
                    held_vel_next = v0_reg;
                    held_acc_next = '0;
                    if (stop_reg)
                    begin
                        phase_next = PH_DECEL;
                        p0_next    = p_lin_reg;
                        seg_reset  = 1'b1;
                    end
                end
                PH_DECEL:
                begin
                    held_pos_next = p_acc_reg;
                    held_vel_next = vel_reg;
                    held_acc_next = acc_neg ? -acc_mag_s : acc_mag_s;
                    if (zero_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE:
                begin
                    if (tgt_reg != accepted_reg)
                    begin
                        phase_next    = PH_ACCEL;
                        p0_next       = held_pos_reg;
                        v0_next       = held_vel_reg;
                        accepted_next = tgt_reg;
                        seg_reset     = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            t_base = seg_reset ? '0 : t_reg;
            t_next = (t_base == TICK_MAX) ? t_base : t_base + 1'b1;
        end
    end

    always_comb
    begin
        max_vel_next = max_vel_reg;
        max_acc_next = max_acc_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAX_VELOCITY: max_vel_next = cfg_data[MAXV_W-1:0];
                CFG_MAX_ACCEL:    max_acc_next = cfg_data[MAXA_W-1:0];
                default:
                begin
                    max_vel_next = max_vel_reg;
                    max_acc_next = max_acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            moving_neg_reg <= 1'b0;
            p0_reg         <= '0;
            v0_reg         <= '0;
            t_reg          <= '0;
            accepted_reg   <= '0;
            held_pos_reg   <= '0;
            held_vel_reg   <= '0;
            held_acc_reg   <= '0;
            max_vel_reg    <= MAXV_RESET;
            max_acc_reg    <= MAXA_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            moving_neg_reg <= moving_neg_next;
            p0_reg         <= p0_next;
            v0_reg         <= v0_next;
            t_reg          <= t_next;
            accepted_reg   <= accepted_next;
            held_pos_reg   <= held_pos_next;
            held_vel_reg   <= held_vel_next;
            held_acc_reg   <= held_acc_next;
            max_vel_reg    <= max_vel_next;
            max_acc_reg    <= max_acc_next;
        end
    end

    // working registers, loaded one step at a time
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg <= target_position;
        end
        case (cmd.op)
            OP_VT:
            begin
                vt_reg <= prod[VT_W-1:0];
            end
            OP_AT:
            begin
                at_reg    <= prod[AT_W-1:0];
                p_lin_reg <= p_lin_next;
            end
            OP_ATT_LO:
            begin
                att_lo_reg <= prod[ATT_LO_W-1:0];
                rem_reg    <= rem_next;
            end
            OP_ATT_HI:
            begin
                att_hi_reg <= prod[AT_W-1:0];
                vel_reg    <= vel_next;
            end
            OP_VV:
            begin
                vv_reg   <= prod[VV_W-1:0];
                half_reg <= half_next;
            end
            OP_REM_LO:
            begin
                ra_lo_reg <= prod[REM_LO_W+MAXA_W-1:0];
                p_acc_reg <= p_acc_next;
            end
            OP_REM_HI:
            begin
                ra_hi_reg <= prod[REM_HI_W+MAXA_W-1:0];
            end
            OP_EVAL:
            begin
                hit_d_reg <= hit_d_next;
                hit_v_reg <= hit_v_next;
                stop_reg  <= stop_next;
                zero_reg  <= zero_next;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.phase_idle = (phase_reg == PH_IDLE);

    assign position     = held_pos_reg;
    assign velocity     = held_vel_reg;
    assign acceleration = held_acc_reg;
    assign phase        = phase_reg;

endmodule

`default_nettype wire

@@ rtl/trapezoidal_trajectory_generator.sv @@
// top level of the trapezoidal trajectory generator
// sequencing: a tick taken while moving runs 8 steps of the shared 32x32 multiplier, then the
//   commit; a tick taken while idle goes straight to the commit; the result shows in the cycle after the commit
// a new tick is taken only once the last one has committed; the commit waits while a result is held unaccepted
// reset: asynchronous, active low; idle phase, all setpoints zero, limits at default values
`default_nettype none

module trapezoidal_trajectory_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ttg_pkg::POS_W-1:0]      target_position,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ttg_pkg::POS_W-1:0]      position,
    output logic signed [ttg_pkg::VEL_W-1:0]      velocity,
    output logic signed [ttg_pkg::ACC_W-1:0]      acceleration,
    output logic [ttg_pkg::PHASE_W-1:0]           phase
);
    import ttg_pkg::*;

    ttg_cmd_t    cmd;
    ttg_status_t sts;

    ttg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ttg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_position (target_position),
        .cmd             (cmd),
        .sts             (sts),
        .position        (position),
        .velocity        (velocity),
        .acceleration    (acceleration),
        .phase           (phase)
    );

endmodule

`default_nettype wire
